/* rtl/cpl_pkg.sv */
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared constants for the closest-points-between-lines datapath.
// ----------------------------------------------------------------------------
package cpl_pkg;

  // default coordinate width (Q.16 fixed point)
  localparam int COORD_WIDTH_DEF = 32;

  // limb width of the partial-product multipliers
  localparam int LIMB_W = 32;

  // parallel threshold register
  localparam int THR_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = 32'd4295;
  // threshold is in units of 2^-32, denominator carries 64 fraction bits
  localparam int THR_SHIFT = 32;

  // result lanes: three axes of near point 1, then three of near point 2
  localparam int NUM_AXES = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;

endpackage

/* rtl/closest_points_between_lines_unit.sv */
// ----------------------------------------------------------------------------
// closest_points_between_lines_unit
// Closest points between two 3D lines given as point and direction, Q.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per line pair:
//   a point and a direction for each line. Output channel (out_valid_o /
//   out_stall_i) returns the two near points plus valid_res, zero_direction
//   and saturated flags. A word moves when valid is high and stall is low.
//   Config channel (cfg_valid_i / cfg_ready_o) writes parallel_threshold;
//   write it only while the pipeline is empty.
// Datapath: three limb multipliers and the W-step divider pipeline.
// Throughput: one word per cycle while out_stall_i does not hold the pipeline.
// Reset: pipeline empties, threshold returns to 4295 (about 1e-6).
// Stall: when a result waits and out_stall_i is high, the whole pipeline
//   holds and in_stall_o rises in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
module closest_points_between_lines_unit #(
  parameter int COORD_WIDTH = cpl_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpl_pkg::THR_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] line1_point_x_i,
  input  logic signed [COORD_WIDTH-1:0] line1_point_y_i,
  input  logic signed [COORD_WIDTH-1:0] line1_point_z_i,
  input  logic signed [COORD_WIDTH-1:0] line1_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] line1_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] line1_dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] line2_point_x_i,
  input  logic signed [COORD_WIDTH-1:0] line2_point_y_i,
  input  logic signed [COORD_WIDTH-1:0] line2_point_z_i,
  input  logic signed [COORD_WIDTH-1:0] line2_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] line2_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] line2_dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] near1_x_o,
  output logic signed [COORD_WIDTH-1:0] near1_y_o,
  output logic signed [COORD_WIDTH-1:0] near1_z_o,
  output logic signed [COORD_WIDTH-1:0] near2_x_o,
  output logic signed [COORD_WIDTH-1:0] near2_y_o,
  output logic signed [COORD_WIDTH-1:0] near2_z_o,
  output logic                          valid_res_o,
  output logic                          zero_direction_o,
  output logic                          saturated_o
);

  localparam int W   = COORD_WIDTH;
  localparam int NA  = cpl_pkg::NUM_AXES;
  localparam int NL  = cpl_pkg::NUM_LANES;
  localparam int LW  = cpl_pkg::LIMB_W;
  localparam int DW  = 2 * W + 3;        // a..e
  localparam int NW  = 2 * DW + 1;       // den, numerators
  localparam int TW  = NW + W;           // dir * numerator
  localparam int P1W = 2 * W + 1;
  localparam int P2W = 2 * DW;
  localparam int EW  = W + 2;
  localparam int M1  = (W + LW - 1) / LW + 4;
  localparam int M2  = (DW + LW - 1) / LW + 4;
  localparam int M3  = M1;
  localparam int DL  = W + 3;
  localparam int TOTAL = 1 + M1 + 1 + M2 + 3 + M3 + DL + 1;
  localparam int VW  = 12 * W;                  // p1, p2, d1, d2
  localparam int S2W = VW + 2 * DW;             // plus c, e
  localparam int S3W = 6 * W + 2 + 2 * NW;
  localparam int S4W = 6 * W + 2;

  typedef logic [NA-1:0][W-1:0] vec_t;

  // ---- control ----
  logic [cpl_pkg::THR_W-1:0] thr_q;
  logic [TOTAL-1:0]          vld_q;
  logic                      en;

  assign en          = !(vld_q[TOTAL-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[TOTAL-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cpl_pkg::THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (en) begin
        vld_q <= {vld_q[TOTAL-2:0], in_valid_i};
      end
    end
  end

  // ---- T0: input register ----
  vec_t p1_q, d1_q, p2_q, d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= {line1_point_z_i, line1_point_y_i, line1_point_x_i};
      d1_q <= {line1_dir_z_i, line1_dir_y_i, line1_dir_x_i};
      p2_q <= {line2_point_z_i, line2_point_y_i, line2_point_x_i};
      d2_q <= {line2_dir_z_i, line2_dir_y_i, line2_dir_x_i};
    end
  end

  // ---- products for a = D1.D1, b = D1.D2, c = D2.D2, d = D1.r, e = D2.r ----
  logic [5*NA-1:0][W:0]    m1_a;
  logic [5*NA-1:0][W-1:0]  m1_b;
  logic [5*NA-1:0][P1W-1:0] m1_p;
  logic [VW-1:0]           m1_side;
  logic signed [W:0]       r [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      r[k] = (W+1)'($signed(p1_q[k])) - (W+1)'($signed(p2_q[k]));
      m1_a[k]        = (W+1)'($signed(d1_q[k]));
      m1_b[k]        = d1_q[k];
      m1_a[NA+k]     = (W+1)'($signed(d1_q[k]));
      m1_b[NA+k]     = d2_q[k];
      m1_a[2*NA+k]   = (W+1)'($signed(d2_q[k]));
      m1_b[2*NA+k]   = d2_q[k];
      m1_a[3*NA+k]   = r[k];
      m1_b[3*NA+k]   = d1_q[k];
      m1_a[4*NA+k]   = r[k];
      m1_b[4*NA+k]   = d2_q[k];
    end
  end

  cpl_mul #(.WA(W + 1), .WB(W), .N(5 * NA), .SW(VW)) u_mul_dot (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (m1_a),
    .b_i    (m1_b),
    .side_i ({p1_q, p2_q, d1_q, d2_q}),
    .p_o    (m1_p),
    .side_o (m1_side)
  );

  // ---- T1: dot product sums ----
  logic signed [DW-1:0] dot_d [5];
  logic signed [DW-1:0] a1_q, b1_q, c1_q, d1s_q, e1_q;
  logic [VW-1:0]        s1_q;

  always_comb begin
    for (int g = 0; g < 5; g++) begin
      dot_d[g] = DW'($signed(m1_p[g*NA]))
               + DW'($signed(m1_p[g*NA+1]))
               + DW'($signed(m1_p[g*NA+2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= dot_d[0];
      b1_q  <= dot_d[1];
      c1_q  <= dot_d[2];
      d1s_q <= dot_d[3];
      e1_q  <= dot_d[4];
      s1_q  <= m1_side;
    end
  end

  // ---- second products: ac, bb, be, cd, ae, bd ----
  logic [5:0][DW-1:0]  m2_a, m2_b;
  logic [5:0][P2W-1:0] m2_p;
  logic [S2W-1:0]      m2_side;

  assign m2_a = {b1_q, a1_q, c1_q, b1_q, b1_q, a1_q};
  assign m2_b = {d1s_q, e1_q, d1s_q, e1_q, b1_q, c1_q};

  cpl_mul #(.WA(DW), .WB(DW), .N(6), .SW(S2W)) u_mul_den (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (m2_a),
    .b_i    (m2_b),
    .side_i ({s1_q, c1_q, e1_q}),
    .p_o    (m2_p),
    .side_o (m2_side)
  );

  // ---- T2: den = ac - bb, ns = be - cd, nt = ae - bd ----
  logic signed [NW-1:0] den2_q, ns2_q, nt2_q;
  logic [S2W-1:0]       s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den2_q <= NW'($signed(m2_p[0])) - NW'($signed(m2_p[1]));
      ns2_q  <= NW'($signed(m2_p[2])) - NW'($signed(m2_p[3]));
      nt2_q  <= NW'($signed(m2_p[4])) - NW'($signed(m2_p[5]));
      s2_q   <= m2_side;
    end
  end

  // ---- T3: fold the sign of den into the numerators ----
  logic [NW-1:0]        aden3_q;
  logic signed [NW-1:0] ns3_q, nt3_q;
  logic                 dzero3_q;
  logic [S2W-1:0]       s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      aden3_q  <= den2_q[NW-1] ? (~den2_q + NW'(1)) : den2_q;
      ns3_q    <= den2_q[NW-1] ? (~ns2_q + NW'(1)) : ns2_q;
      nt3_q    <= den2_q[NW-1] ? (~nt2_q + NW'(1)) : nt2_q;
      dzero3_q <= (den2_q == '0);
      s3_q     <= s2_q;
    end
  end

  // ---- T4: parallel test and fallback select ----
  vec_t                 p1_3, p2_3, d1_3, d2_3;
  logic signed [DW-1:0] c3, e3;
  logic                 skew_d;

  assign {p1_3, p2_3, d1_3, d2_3, c3, e3} = s3_q;
  assign skew_d = !dzero3_q
               && (aden3_q >= NW'({thr_q, {cpl_pkg::THR_SHIFT{1'b0}}}));

  logic signed [NW-1:0] ns4_q, n24_q;
  logic [NW-1:0]        dv14_q, dv24_q;
  logic                 skew4_q, zdir4_q;
  vec_t                 p1_4, p2_4, d1_4, d2_4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ns4_q   <= ns3_q;
      n24_q   <= skew_d ? nt3_q : NW'(e3);
      dv14_q  <= aden3_q;
      dv24_q  <= skew_d ? aden3_q : NW'($unsigned(c3));
      skew4_q <= skew_d;
      zdir4_q <= (c3 == '0);
      p1_4    <= p1_3;
      p2_4    <= p2_3;
      d1_4    <= d1_3;
      d2_4    <= d2_3;
    end
  end

  // ---- third products: direction * numerator ----
  logic [NL-1:0][NW-1:0] m3_a;
  logic [NL-1:0][W-1:0]  m3_b;
  logic [NL-1:0][TW-1:0] m3_p;
  logic [S3W-1:0]        m3_side;

  assign m3_a = {n24_q, n24_q, n24_q, ns4_q, ns4_q, ns4_q};
  assign m3_b = {d2_4, d1_4};

  cpl_mul #(.WA(NW), .WB(W), .N(NL), .SW(S3W)) u_mul_off (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (m3_a),
    .b_i    (m3_b),
    .side_i ({p1_4, p2_4, skew4_q, zdir4_q, dv14_q, dv24_q}),
    .p_o    (m3_p),
    .side_o (m3_side)
  );

  // ---- rounding divide ----
  vec_t                  p1_5, p2_5;
  logic                  skew5, zdir5;
  logic [NW-1:0]         dv15, dv25;
  logic [NL-1:0][NW-1:0] dv_lane;
  logic [NL-1:0][W-1:0]  q6;
  logic [NL-1:0]         ovf6, neg6;
  logic [S4W-1:0]        s6;

  assign {p1_5, p2_5, skew5, zdir5, dv15, dv25} = m3_side;
  assign dv_lane = {dv25, dv25, dv25, dv15, dv15, dv15};

  cpl_div #(.QW(W), .NUMW(TW), .DIVW(NW), .N(NL), .SW(S4W)) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (m3_p),
    .div_i  (dv_lane),
    .side_i ({p1_5, p2_5, skew5, zdir5}),
    .q_o    (q6),
    .ovf_o  (ovf6),
    .neg_o  (neg6),
    .side_o (s6)
  );

  // ---- T5: add to point, saturate, output register ----
  vec_t                 p1_6, p2_6;
  logic                 skew6, zdir6;
  logic [NL-1:0][W-1:0] pt6;
  logic [NL-1:0][W-1:0] near_d;
  logic [NL-1:0]        sat_d;
  logic signed [EW-1:0] qx [NL];
  logic signed [EW-1:0] sum [NL];
  logic                 use_off [NL];

  assign {p1_6, p2_6, skew6, zdir6} = s6;
  assign pt6 = {p2_6, p1_6};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      use_off[l] = (l < NA) ? skew6 : (skew6 || !zdir6);
      qx[l]      = EW'(q6[l]);
      sum[l]     = EW'($signed(pt6[l])) + (neg6[l] ? -qx[l] : qx[l]);
      sat_d[l]   = 1'b0;
      near_d[l]  = pt6[l];
      if (use_off[l]) begin
        if (ovf6[l]) begin
          sat_d[l]  = 1'b1;
          near_d[l] = neg6[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else if ((sum[l][EW-1:W-1] != '0) && (sum[l][EW-1:W-1] != '1)) begin
          // out of range: clip toward the sign of the sum
          sat_d[l]  = 1'b1;
          near_d[l] = sum[l][EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          near_d[l] = sum[l][W-1:0];
        end
      end
    end
  end

  logic [NL-1:0][W-1:0] near_q;
  logic                 skew_q, zdir_q, sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      near_q <= near_d;
      skew_q <= skew6;
      zdir_q <= !skew6 && zdir6;
      sat_q  <= |sat_d;
    end
  end

  assign near1_x_o        = near_q[0];
  assign near1_y_o        = near_q[1];
  assign near1_z_o        = near_q[2];
  assign near2_x_o        = near_q[3];
  assign near2_y_o        = near_q[4];
  assign near2_z_o        = near_q[5];
  assign valid_res_o      = skew_q;
  assign zero_direction_o = zdir_q;
  assign saturated_o      = sat_q;

endmodule

/* rtl/cpl_mul.sv */
// ----------------------------------------------------------------------------
// cpl_mul
// Pipelined signed multiplier, N lanes, built from 32x32 limb products.
// A side word travels along unchanged, delayed to match the product.
// ----------------------------------------------------------------------------
module cpl_mul #(
  parameter int WA = 33,
  parameter int WB = 32,
  parameter int N  = 1,
  parameter int SW = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [N-1:0][WA-1:0]      a_i,
  input  logic [N-1:0][WB-1:0]      b_i,
  input  logic [SW-1:0]             side_i,
  output logic [N-1:0][WA+WB-1:0]   p_o,
  output logic [SW-1:0]             side_o
);

  localparam int LW  = cpl_pkg::LIMB_W;
  localparam int PPW = 2 * LW;
  localparam int LA  = (WA + LW - 1) / LW;
  localparam int LB  = (WB + LW - 1) / LW;
  localparam int MAW = LA * LW;
  localparam int MBW = LB * LW;
  localparam int RW  = (LA + 1) * LW;
  localparam int AW  = (LA + LB) * LW;
  localparam int PW  = WA + WB;
  localparam int LAT = LB + 4;

  logic [SW-1:0] side_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_o = side_q[LAT-1];

  for (genvar n = 0; n < N; n++) begin : g_lane
    logic [WA-1:0]  amag;
    logic [WB-1:0]  bmag;
    logic [MAW-1:0] ma_q;
    logic [MBW-1:0] mb_q;
    logic           neg_q [LAT-1];
    logic [PPW-1:0] pp_q [LB][LA];
    logic [RW-1:0]  ev [LB];
    logic [RW-1:0]  od [LB];
    logic [RW-1:0]  row_q [LB];
    logic [RW-1:0]  rowd_q [LB][LB];
    logic [AW-1:0]  acc_q [LB];
    logic [AW-1:0]  accn;
    logic [PW-1:0]  p_q;

    // magnitudes; the most negative value still fits unsigned
    assign amag = a_i[n][WA-1] ? (~a_i[n] + WA'(1)) : a_i[n];
    assign bmag = b_i[n][WB-1] ? (~b_i[n] + WB'(1)) : b_i[n];

    // even and odd limb products do not overlap, so each row is one add
    always_comb begin
      for (int i = 0; i < LB; i++) begin
        ev[i] = '0;
        od[i] = '0;
        for (int j = 0; j < LA; j++) begin
          if ((j % 2) == 0) begin
            ev[i][j*LW +: PPW] = pp_q[i][j];
          end else begin
            od[i][j*LW +: PPW] = pp_q[i][j];
          end
        end
      end
    end

    assign accn = neg_q[LAT-2] ? (~acc_q[LB-1] + AW'(1)) : acc_q[LB-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ma_q     <= MAW'(amag);
        mb_q     <= MBW'(bmag);
        neg_q[0] <= a_i[n][WA-1] ^ b_i[n][WB-1];
        for (int k = 1; k < LAT - 1; k++) begin
          neg_q[k] <= neg_q[k-1];
        end
        for (int i = 0; i < LB; i++) begin
          for (int j = 0; j < LA; j++) begin
            pp_q[i][j] <= PPW'(mb_q[i*LW +: LW]) * PPW'(ma_q[j*LW +: LW]);
          end
          row_q[i] <= ev[i] + od[i];
        end
        acc_q[0]  <= AW'(row_q[0]);
        rowd_q[0] <= row_q;
        for (int k = 1; k < LB; k++) begin
          acc_q[k]  <= acc_q[k-1] + (AW'(rowd_q[k-1][k]) << (k * LW));
          rowd_q[k] <= rowd_q[k-1];
        end
        p_q <= accn[PW-1:0];
      end
    end

    assign p_o[n] = p_q;
  end

endmodule

/* rtl/cpl_div.sv */
// ----------------------------------------------------------------------------
// cpl_div
// Pipelined rounding divider, N lanes: round(num/div), ties away from zero.
// Gives QW quotient bits of the magnitude plus an overflow flag when the
// quotient reaches 2^QW. One restoring step per stage.
// ----------------------------------------------------------------------------
module cpl_div #(
  parameter int QW   = 32,
  parameter int NUMW = 167,
  parameter int DIVW = 135,
  parameter int N    = 1,
  parameter int SW   = 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [N-1:0][NUMW-1:0]  num_i,
  input  logic [N-1:0][DIVW-1:0]  div_i,
  input  logic [SW-1:0]           side_i,
  output logic [N-1:0][QW-1:0]    q_o,
  output logic [N-1:0]            ovf_o,
  output logic [N-1:0]            neg_o,
  output logic [SW-1:0]           side_o
);

  localparam int RW  = NUMW + 2;
  localparam int LAT = QW + 3;

  logic [SW-1:0] side_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_o = side_q[LAT-1];

  for (genvar n = 0; n < N; n++) begin : g_lane
    logic [NUMW-1:0] mag_q;
    logic [DIVW-1:0] m_q;
    logic [RW-1:0]   n_q;
    logic [DIVW:0]   m2s_q;
    logic            neg_q [LAT];
    logic [RW-1:0]   rem_q [QW+1];
    logic [DIVW:0]   m2_q [QW+1];
    logic [QW-1:0]   q_q [QW+1];
    logic            ovf_q [QW+1];
    logic [RW-1:0]   sh [QW+1];
    logic            ge [QW+1];

    always_comb begin
      sh[0] = '0;
      ge[0] = 1'b0;
      for (int s = 1; s <= QW; s++) begin
        sh[s] = RW'(m2_q[s-1]) << (QW - s);
        ge[s] = rem_q[s-1] >= sh[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q    <= num_i[n][NUMW-1] ? (~num_i[n] + NUMW'(1)) : num_i[n];
        m_q      <= div_i[n];
        neg_q[0] <= num_i[n][NUMW-1];
        for (int k = 1; k < LAT; k++) begin
          neg_q[k] <= neg_q[k-1];
        end
        // 2|x| + m over 2m gives round half away from zero
        n_q      <= (RW'(mag_q) << 1) + RW'(m_q);
        m2s_q    <= {m_q, 1'b0};
        rem_q[0] <= n_q;
        m2_q[0]  <= m2s_q;
        q_q[0]   <= '0;
        ovf_q[0] <= n_q >= (RW'(m2s_q) << QW);
        for (int s = 1; s <= QW; s++) begin
          rem_q[s] <= ge[s] ? (rem_q[s-1] - sh[s]) : rem_q[s-1];
          q_q[s]   <= q_q[s-1] | (ge[s] ? (QW'(1) << (QW - s)) : QW'(0));
          m2_q[s]  <= m2_q[s-1];
          ovf_q[s] <= ovf_q[s-1];
        end
      end
    end

    assign q_o[n]   = q_q[QW];
    assign ovf_o[n] = ovf_q[QW];
    assign neg_o[n] = neg_q[LAT-1];
  end

endmodule
